@@ rtl/pbsr_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the slot ring.
package pbsr_pkg;

    // Ring geometry and cookie width.
    localparam int INDEX_BITS  = 6;
    localparam int COOKIE_BITS = 24;
    localparam int NUM_SLOTS   = 1 << INDEX_BITS;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Highest cookie value that is produced; incrementing it wraps to zero.
    localparam logic [COOKIE_BITS-1:0] COOKIE_LAST = {{(COOKIE_BITS-1){1'b1}}, 1'b0};

    // Reset value of the hold time register.
    localparam logic [15:0] HOLD_RESET = 16'd1000;

    // Operation codes carried in the input tuser.
    typedef enum logic [2:0] {
        OP_SAVE     = 3'd0,
        OP_RETRIEVE = 3'd1,
        OP_DISCARD  = 3'd2,
        OP_FLUSH    = 3'd3,
        OP_TICK     = 3'd4
    } pbsr_op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_HELD     = 2'd1,
        ST_NO_MATCH = 2'd2
    } pbsr_status_t;

    // Handle kinds reported with a result.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_USE  = 2'd1,
        KIND_FREE = 2'd2
    } pbsr_kind_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FLUSH_SCAN,
        S_FLUSH_EMIT,
        S_FLUSH_EMPTY
    } pbsr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic exec;
        logic scan;
        logic next;
        logic emit;
        logic emit_empty;
    } pbsr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic occ_hit;
        logic budget_ok;
        logic scan_end;
        logic count_zero;
        logic out_free;
    } pbsr_stat_t;

endpackage

@@ rtl/pbsr_ctrl.sv @@
// Controller state machine that sequences item execution and the flush walk.
module pbsr_ctrl import pbsr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [2:0] s_op,
    output logic       s_ready,
    input  pbsr_stat_t stat,
    output pbsr_cmd_t  cmd
);

    pbsr_state_t state_reg;
    pbsr_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take = 1'b1;
                    case (s_op)
                        OP_SAVE, OP_RETRIEVE, OP_DISCARD: state_next = S_EXEC;
                        OP_FLUSH:                         state_next = S_FLUSH_SCAN;
                        default:                          state_next = S_IDLE;
                    endcase
                end
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH_SCAN: begin
                // Every visited slot is cleared; reported ones wait for the output.
                cmd.scan = 1'b1;
                if (stat.occ_hit && stat.budget_ok) begin
                    state_next = S_FLUSH_EMIT;
                end else if (stat.scan_end) begin
                    state_next = stat.count_zero ? S_FLUSH_EMPTY : S_IDLE;
                end else begin
                    cmd.next = 1'b1;
                end
            end
            S_FLUSH_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.scan_end) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.next   = 1'b1;
                        state_next = S_FLUSH_SCAN;
                    end
                end
            end
            S_FLUSH_EMPTY: begin
                if (stat.out_free) begin
                    cmd.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/pbsr_datapath.sv @@
// Datapath: slot memories, occupancy bits, time base, flush walk and result register.
module pbsr_datapath import pbsr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic [2:0]  s_op,
    input  logic [31:0] s_handle,
    input  logic [31:0] s_slot_tag,
    output logic [1:0]  m_status,
    output logic [31:0] m_new_id,
    output logic [31:0] m_handle_out,
    output logic [1:0]  m_handle_kind,
    output logic        m_last,
    output logic        m_valid,
    input  logic        m_ready,
    input  pbsr_cmd_t   cmd,
    output pbsr_stat_t  stat
);

    // Slot memories.
    logic [31:0]            slot_handle_reg [NUM_SLOTS];
    logic [31:0]            slot_expiry_reg [NUM_SLOTS];
    logic [COOKIE_BITS-1:0] slot_cookie_reg [NUM_SLOTS];

    // Control and state registers.
    logic [15:0]            hold_reg;
    logic [31:0]            time_reg,       time_next;
    logic [INDEX_BITS-1:0]  ring_reg,       ring_next;
    logic [NUM_SLOTS-1:0]   occ_reg,        occ_next;
    logic [NUM_SLOTS-1:0]   cookie_vld_reg, cookie_vld_next;
    logic [INDEX_BITS-1:0]  scan_reg,       scan_next;
    logic [CNT_W-1:0]       count_reg,      count_next;
    logic                   flush_last_reg;

    // Item being executed.
    logic [2:0]             op_reg;
    logic [31:0]            pkt_reg;
    logic [31:0]            id_reg;
    logic [INDEX_BITS-1:0]  slot_reg;

    // Registered memory read data.
    logic [31:0]            handle_rd_reg;
    logic [31:0]            expiry_rd_reg;
    logic [COOKIE_BITS-1:0] cookie_rd_reg;
    logic                   cookie_vld_rd_reg;

    // Result register.
    logic                   out_valid_reg,  out_valid_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic [31:0]            out_id_reg,     out_id_next;
    logic [31:0]            out_handle_reg, out_handle_next;
    logic [1:0]             out_kind_reg,   out_kind_next;
    logic                   out_last_reg,   out_last_next;

    // Combinational helpers.
    logic [INDEX_BITS-1:0]             take_slot;
    logic [INDEX_BITS-1:0]             rd_addr;
    logic [COOKIE_BITS-1:0]            cookie_cur;
    logic [COOKIE_BITS-1:0]            cookie_inc;
    logic [COOKIE_BITS+31:0]           cookie_wide;
    logic [COOKIE_BITS+31:0]           id_cookie_wide;
    logic [COOKIE_BITS+INDEX_BITS+31:0] new_id_wide;
    logic [31:0]                       age;
    logic [31:0]                       expiry_new;
    logic                              slot_occ;
    logic                              held;
    logic                              match;
    logic                              save_wr;
    logic                              is_save;
    logic                              is_claim;
    logic                              more_above;
    logic                              out_load;

    // Slot addressed by a new item: saves use the advanced ring index.
    assign take_slot = (s_op == OP_SAVE) ? ring_reg + INDEX_BITS'(1)
                                         : s_slot_tag[INDEX_BITS-1:0];
    assign rd_addr   = cmd.take ? take_slot : scan_reg;

    // Slot evaluation for save, retrieve and discard.
    assign is_save        = (op_reg == OP_SAVE);
    assign is_claim       = (op_reg == OP_RETRIEVE) || (op_reg == OP_DISCARD);
    assign cookie_cur     = cookie_vld_rd_reg ? cookie_rd_reg : '0;
    assign cookie_inc     = (cookie_cur == COOKIE_LAST) ? '0
                                                        : cookie_cur + COOKIE_BITS'(1);
    assign slot_occ       = occ_reg[slot_reg];
    assign age            = time_reg - expiry_rd_reg;
    assign held           = slot_occ && age[31];
    assign cookie_wide    = {32'd0, cookie_cur};
    assign id_cookie_wide = {{COOKIE_BITS{1'b0}}, id_reg} >> INDEX_BITS;
    assign match          = slot_occ && (cookie_wide == id_cookie_wide);
    assign new_id_wide    = {32'd0, cookie_inc, slot_reg};
    assign expiry_new     = time_reg + {16'd0, hold_reg};
    assign save_wr        = cmd.exec && is_save && !held;

    // Whether any occupied slot lies above the one being scanned.
    assign more_above = |((occ_reg >> scan_reg) >> 1);

    // Status toward the controller.
    assign stat.occ_hit    = occ_reg[scan_reg];
    assign stat.budget_ok  = (count_reg < CNT_W'(MAX_RESULTS));
    assign stat.scan_end   = (scan_reg == {INDEX_BITS{1'b1}});
    assign stat.count_zero = (count_reg == '0);
    assign stat.out_free   = !out_valid_reg || m_ready;

    // Slot memories: written on an accepted save, read at item take or during the walk.
    // The read data is held while an item or a flush result waits for the output.
    always_ff @(posedge aclk) begin
        if (save_wr) begin
            slot_handle_reg[slot_reg] <= pkt_reg;
            slot_expiry_reg[slot_reg] <= expiry_new;
            slot_cookie_reg[slot_reg] <= cookie_inc;
        end
        if (cmd.take || cmd.scan) begin
            handle_rd_reg     <= slot_handle_reg[rd_addr];
            expiry_rd_reg     <= slot_expiry_reg[rd_addr];
            cookie_rd_reg     <= slot_cookie_reg[rd_addr];
            cookie_vld_rd_reg <= cookie_vld_reg[rd_addr];
        end
    end

    // Item capture.
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg   <= s_op;
            pkt_reg  <= s_handle;
            id_reg   <= s_slot_tag;
            slot_reg <= take_slot;
        end
        if (cmd.scan) begin
            flush_last_reg <= !more_above || (count_reg == CNT_W'(MAX_RESULTS - 1));
        end
    end

    // Next values of the slot state, time base and walk counters.
    always_comb begin
        occ_next        = occ_reg;
        cookie_vld_next = cookie_vld_reg;
        ring_next       = ring_reg;
        time_next       = time_reg;
        scan_next       = scan_reg;
        count_next      = count_reg;
        if (cmd.take) begin
            scan_next  = '0;
            count_next = '0;
            if (s_op == OP_TICK) begin
                time_next = time_reg + 32'd1;
            end
        end
        if (cmd.exec && is_save) begin
            ring_next = slot_reg;
        end
        if (save_wr) begin
            occ_next[slot_reg]        = 1'b1;
            cookie_vld_next[slot_reg] = 1'b1;
        end
        if (cmd.exec && is_claim && match) begin
            occ_next[slot_reg] = 1'b0;
        end
        if (cmd.scan) begin
            occ_next[scan_reg] = 1'b0;
        end
        if (cmd.next) begin
            scan_next = scan_reg + INDEX_BITS'(1);
        end
        if (cmd.emit) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Result register contents.
    always_comb begin
        out_load        = cmd.exec || cmd.emit || cmd.emit_empty;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_handle_next = out_handle_reg;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        if (cmd.exec) begin
            out_last_next = 1'b1;
            if (is_save) begin
                if (held) begin
                    out_status_next = ST_HELD;
                    out_id_next     = '1;
                    out_handle_next = '0;
                    out_kind_next   = KIND_NONE;
                end else begin
                    out_status_next = ST_DONE;
                    out_id_next     = new_id_wide[31:0];
                    out_handle_next = slot_occ ? handle_rd_reg : '0;
                    out_kind_next   = slot_occ ? KIND_FREE : KIND_NONE;
                end
            end else if (match) begin
                out_status_next = ST_DONE;
                out_id_next     = '0;
                out_handle_next = handle_rd_reg;
                out_kind_next   = (op_reg == OP_RETRIEVE) ? KIND_USE : KIND_FREE;
            end else begin
                out_status_next = ST_NO_MATCH;
                out_id_next     = '0;
                out_handle_next = '0;
                out_kind_next   = KIND_NONE;
            end
        end else if (cmd.emit) begin
            out_status_next = ST_DONE;
            out_id_next     = '0;
            out_handle_next = handle_rd_reg;
            out_kind_next   = KIND_FREE;
            out_last_next   = flush_last_reg;
        end else if (cmd.emit_empty) begin
            out_status_next = ST_DONE;
            out_id_next     = '0;
            out_handle_next = '0;
            out_kind_next   = KIND_NONE;
            out_last_next   = 1'b1;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_handle_reg <= out_handle_next;
        out_kind_reg   <= out_kind_next;
        out_last_reg   <= out_last_next;
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg       <= HOLD_RESET;
            time_reg       <= '0;
            ring_reg       <= '0;
            occ_reg        <= '0;
            cookie_vld_reg <= '0;
            scan_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                hold_reg <= cfg_wr_data;
            end
            time_reg       <= time_next;
            ring_reg       <= ring_next;
            occ_reg        <= occ_next;
            cookie_vld_reg <= cookie_vld_next;
            scan_reg       <= scan_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign m_status      = out_status_reg;
    assign m_new_id      = out_id_reg;
    assign m_handle_out  = out_handle_reg;
    assign m_handle_kind = out_kind_reg;
    assign m_last        = out_last_reg;
    assign m_valid       = out_valid_reg;

endmodule

@@ rtl/packet_buffer_slot_ring_unit.sv @@
// Top level of the packet buffer slot ring: stream ports, controller and datapath.
//
// The block keeps a ring of 64 packet-handle slots, each guarded by a 24-bit
// generation cookie. Items arrive on the s_ stream: the operation code travels
// in s_tuser, packet handle and slot tag in s_tdata. Results leave on the m_
// stream with the handle kind in m_tuser and the final result of an item
// marked by m_tlast. The hold time is written through cfg_wr_en/cfg_wr_data.
// Save, retrieve and discard read their slot in the accept cycle and update it
// once the output register is free, loading the result register in that same
// step; a new item is taken only after the update. A tick produces no transfer.
// A flush walks all 64 slots, one per cycle except where an occupied slot is
// reported: each report waits for the output register to be free.
// Reset clears the time base, ring index, occupancy and cookies at once and
// restores the hold time to 1000; no clearing pass is needed. The result sits
// in an output register; while the receiver stalls the block holds it and
// stops at the next result, but a new item is still taken while it waits.
module packet_buffer_slot_ring_unit import pbsr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // packet_handle[31:0], slot_tag[63:32]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // status[1:0], new_id[33:2], handle_out[65:34], zero pad
    output logic [1:0]  m_tuser,   // handle_kind[1:0]
    output logic        m_tlast
);

    pbsr_cmd_t   cmd;
    pbsr_stat_t  stat;
    logic [1:0]  status;
    logic [31:0] new_id;
    logic [31:0] handle_out;

    // Sequencing of items and of the flush walk.
    pbsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_op    (s_tuser),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Slot storage and result generation.
    pbsr_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_op          (s_tuser),
        .s_handle      (s_tdata[31:0]),
        .s_slot_tag    (s_tdata[63:32]),
        .m_status      (status),
        .m_new_id      (new_id),
        .m_handle_out  (handle_out),
        .m_handle_kind (m_tuser),
        .m_last        (m_tlast),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .cmd           (cmd),
        .stat          (stat)
    );

    // Result payload packing.
    assign m_tdata = {6'd0, handle_out, new_id, status};

endmodule
